// ----- rtl/core/imubc_pkg.sv -----
`timescale 1ns / 1ps

package imubc_pkg;

	localparam int AXES      = 6;
	localparam int AXIS_W    = 16;
	localparam int OFFSET_W  = 17;
	localparam int SUM_W     = 24;
	localparam int THR_W     = 16;
	localparam int GRAV_W    = 15;
	localparam int ERR_W     = 32;
	localparam int PHASE_W   = 2;
	localparam int AXIS_ACC_Z = 2;

	// Sums stay below 2^23 in magnitude; this shift keeps the reciprocal
	// product exact for every divisor up to 127.
	localparam int MAG_W     = 23;
	localparam int DIV_SHIFT = 30;
	localparam int RECIP_W   = 31;
	localparam int PROD_W    = MAG_W + RECIP_W;

	localparam logic CFG_STILL_THR = 1'b0;
	localparam logic CFG_GRAVITY   = 1'b1;

	localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_AVG  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_RUN  = 2'd2;

	localparam logic [THR_W-1:0]  THR_RESET  = 16'd400;
	localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd16384;

	typedef struct packed {
		logic take;      // sample beat accepted
		logic restart;   // restart beat accepted
		logic read_ok;
		logic ref_upd;   // store accel reference
		logic sum_clr;
		logic accum;
		logic mul_go;
		logic off_load;
	} lane_ctl_t;

	typedef struct packed {
		logic               busy;
		logic [PHASE_W-1:0] phase_code;
		logic [ERR_W-1:0]   err_next;
		logic [THR_W-1:0]   threshold;
		logic [GRAV_W-1:0]  gravity;
	} ctrl_stat_t;

endpackage

// ----- rtl/core/imubc_lane.sv -----
`timescale 1ns / 1ps

module imubc_lane #(
	parameter int AVG_FRAMES = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  imubc_pkg::lane_ctl_t                ctl,
	input  logic signed [imubc_pkg::AXIS_W-1:0] raw,
	input  logic [imubc_pkg::GRAV_W-1:0]        gravity,
	input  logic [imubc_pkg::THR_W-1:0]         threshold,
	output logic signed [imubc_pkg::AXIS_W-1:0] frame,
	output logic                                still
);

	localparam logic [imubc_pkg::RECIP_W-1:0] RECIP = imubc_pkg::RECIP_W'(
		((64'd1 << imubc_pkg::DIV_SHIFT) + 64'(AVG_FRAMES) - 64'd1) / 64'(AVG_FRAMES));

	logic signed [imubc_pkg::OFFSET_W-1:0] offset_q;
	logic signed [imubc_pkg::AXIS_W-1:0]   last_q;
	logic signed [imubc_pkg::AXIS_W-1:0]   prev_q;
	logic signed [imubc_pkg::SUM_W-1:0]    sum_q;
	logic [imubc_pkg::PROD_W-1:0]          prod_s1;
	logic                                  neg_s1;

	logic [imubc_pkg::AXIS_W-1:0]          corr;
	logic signed [imubc_pkg::AXIS_W:0]     diff;
	logic [imubc_pkg::AXIS_W:0]            abs_d;
	logic signed [imubc_pkg::AXIS_W:0]     val;
	logic [imubc_pkg::SUM_W-1:0]           mag;
	logic [imubc_pkg::PROD_W-1:0]          prod_next;
	logic [imubc_pkg::OFFSET_W-1:0]        quo;

	assign corr  = raw - offset_q[imubc_pkg::AXIS_W-1:0];
	assign frame = ctl.read_ok ? corr : last_q;

	assign diff  = {frame[imubc_pkg::AXIS_W-1], frame} - {prev_q[imubc_pkg::AXIS_W-1], prev_q};
	assign abs_d = diff[imubc_pkg::AXIS_W] ? -diff : diff;
	assign still = abs_d < {1'b0, threshold};

	// gravity is tied to zero on every lane but accel z
	assign val = {frame[imubc_pkg::AXIS_W-1], frame} - {2'b00, gravity};

	assign mag       = sum_q[imubc_pkg::SUM_W-1] ? -sum_q : sum_q;
	assign prod_next = mag[imubc_pkg::MAG_W-1:0] * RECIP;
	assign quo       = prod_s1[imubc_pkg::DIV_SHIFT + imubc_pkg::OFFSET_W - 1:imubc_pkg::DIV_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			last_q   <= '0;
			prev_q   <= '0;
			sum_q    <= '0;
		end else begin
			if (ctl.restart) begin
				offset_q <= '0;
				prev_q   <= '0;
				sum_q    <= '0;
			end else begin
				if (ctl.take) begin
					last_q <= frame;
				end
				if (ctl.ref_upd) begin
					prev_q <= frame;
				end
				if (ctl.sum_clr) begin
					sum_q <= '0;
				end else if (ctl.accum) begin
					sum_q <= sum_q + {{(imubc_pkg::SUM_W - imubc_pkg::AXIS_W - 1){val[imubc_pkg::AXIS_W]}}, val};
				end
				if (ctl.off_load) begin
					offset_q <= neg_s1 ? -quo : quo;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_go) begin
			prod_s1 <= prod_next;
			neg_s1  <= sum_q[imubc_pkg::SUM_W-1];
		end
	end

endmodule

// ----- rtl/core/imubc_ctrl.sv -----
`timescale 1ns / 1ps

module imubc_ctrl #(
	parameter int STILL_FRAMES   = 100,
	parameter int AVERAGE_FRAMES = 100
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  command,
	input  logic                  read_ok,
	input  logic [2:0]            still,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data,
	output imubc_pkg::lane_ctl_t  ctl,
	output imubc_pkg::ctrl_stat_t stat
);

	localparam int RUN_W = $clog2(STILL_FRAMES + 1);
	localparam int CNT_W = $clog2(AVERAGE_FRAMES + 1);

	typedef enum logic [4:0] {
		ST_WAIT = 5'b00001,
		ST_AVG  = 5'b00010,
		ST_DIV1 = 5'b00100,
		ST_DIV2 = 5'b01000,
		ST_RUN  = 5'b10000
	} cal_state_t;

	cal_state_t                     state_q;
	logic                           have_ref_q;
	logic [RUN_W-1:0]               still_run_q;
	logic [CNT_W-1:0]               avg_cnt_q;
	logic [imubc_pkg::ERR_W-1:0]    err_q;
	logic [imubc_pkg::THR_W-1:0]    thr_q;
	logic [imubc_pkg::GRAV_W-1:0]   grav_q;

	logic                           take;
	logic                           restart;
	logic                           all_still;
	logic [RUN_W-1:0]               run_next;
	logic [CNT_W-1:0]               cnt_next;
	logic                           go_avg;
	logic                           go_div;

	assign take      = accept && !command;
	assign restart   = accept && command;
	assign all_still = &still;
	assign run_next  = !have_ref_q ? still_run_q : (all_still ? still_run_q + 1'b1 : '0);
	assign cnt_next  = avg_cnt_q + 1'b1;
	assign go_avg    = take && (state_q == ST_WAIT) && (run_next >= RUN_W'(STILL_FRAMES));
	assign go_div    = take && (state_q == ST_AVG) && (cnt_next >= CNT_W'(AVERAGE_FRAMES));

	always_comb begin
		ctl.take     = take;
		ctl.restart  = restart;
		ctl.read_ok  = read_ok;
		ctl.ref_upd  = take && (state_q == ST_WAIT);
		ctl.sum_clr  = go_avg;
		ctl.accum    = take && (state_q == ST_AVG);
		ctl.mul_go   = state_q == ST_DIV1;
		ctl.off_load = state_q == ST_DIV2;
	end

	always_comb begin
		stat.busy      = (state_q == ST_DIV1) || (state_q == ST_DIV2);
		stat.err_next  = err_q + imubc_pkg::ERR_W'(take && !read_ok);
		stat.threshold = thr_q;
		stat.gravity   = grav_q;
		unique case (state_q)
			ST_WAIT: stat.phase_code = imubc_pkg::PHASE_WAIT;
			ST_AVG:  stat.phase_code = imubc_pkg::PHASE_AVG;
			default: stat.phase_code = imubc_pkg::PHASE_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			have_ref_q  <= 1'b0;
			still_run_q <= '0;
			avg_cnt_q   <= '0;
			err_q       <= '0;
			thr_q       <= imubc_pkg::THR_RESET;
			grav_q      <= imubc_pkg::GRAV_RESET;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					imubc_pkg::CFG_STILL_THR: thr_q  <= cfg_data;
					imubc_pkg::CFG_GRAVITY:   grav_q <= cfg_data[imubc_pkg::GRAV_W-1:0];
				endcase
			end
			if (accept) begin
				err_q <= stat.err_next;
			end
			if (restart) begin
				state_q     <= ST_WAIT;
				have_ref_q  <= 1'b0;
				still_run_q <= '0;
				avg_cnt_q   <= '0;
			end else begin
				unique case (state_q)
					ST_WAIT: begin
						if (take) begin
							have_ref_q  <= 1'b1;
							still_run_q <= run_next;
							if (go_avg) begin
								state_q   <= ST_AVG;
								avg_cnt_q <= '0;
							end
						end
					end
					ST_AVG: begin
						if (take) begin
							avg_cnt_q <= cnt_next;
							if (go_div) begin
								state_q <= ST_DIV1;
							end
						end
					end
					ST_DIV1: state_q <= ST_DIV2;
					ST_DIV2: state_q <= ST_RUN;
					default: state_q <= ST_RUN;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/imu_bias_calibrate_correct_unit.sv -----
`timescale 1ns / 1ps

// An accepted input beat is registered straight into the output register.
// Throughput: one beat per cycle unless a stalled output beat holds the input; after the last
// averaging beat the input stalls in ST_DIV1 and ST_DIV2 while the six lane multipliers turn sums into offsets.
// Reset (arst_n low, asynchronous) clears offsets, sums, counters and the
// error count and restores still_threshold = 400, gravity_lsb = 16384.
module imu_bias_calibrate_correct_unit #(
	parameter int STILL_FRAMES   = 100,
	parameter int AVERAGE_FRAMES = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic               read_ok,
	input  logic signed [15:0] acc_x_raw,
	input  logic signed [15:0] acc_y_raw,
	input  logic signed [15:0] acc_z_raw,
	input  logic signed [15:0] gyro_x_raw,
	input  logic signed [15:0] gyro_y_raw,
	input  logic signed [15:0] gyro_z_raw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] acc_x_out,
	output logic signed [15:0] acc_y_out,
	output logic signed [15:0] acc_z_out,
	output logic signed [15:0] gyro_x_out,
	output logic signed [15:0] gyro_y_out,
	output logic signed [15:0] gyro_z_out,
	output logic               held,
	output logic [1:0]         phase,
	output logic [31:0]        error_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	imubc_pkg::lane_ctl_t  ctl;
	imubc_pkg::ctrl_stat_t stat;

	logic                                accept;
	logic signed [imubc_pkg::AXIS_W-1:0] raw   [imubc_pkg::AXES];
	logic signed [imubc_pkg::AXIS_W-1:0] frame [imubc_pkg::AXES];
	logic [imubc_pkg::AXES-1:0]          still;

	logic                                out_valid_q;
	logic signed [imubc_pkg::AXIS_W-1:0] axis_q [imubc_pkg::AXES];
	logic                                held_q;
	logic [imubc_pkg::PHASE_W-1:0]       phase_q;
	logic [imubc_pkg::ERR_W-1:0]         err_q;

	assign in_stall  = stat.busy || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign raw[0] = acc_x_raw;
	assign raw[1] = acc_y_raw;
	assign raw[2] = acc_z_raw;
	assign raw[3] = gyro_x_raw;
	assign raw[4] = gyro_y_raw;
	assign raw[5] = gyro_z_raw;

	imubc_ctrl #(
		.STILL_FRAMES  (STILL_FRAMES),
		.AVERAGE_FRAMES(AVERAGE_FRAMES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.read_ok  (read_ok),
		.still    (still[2:0]),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.stat     (stat)
	);

	for (genvar i = 0; i < imubc_pkg::AXES; i++) begin : g_lane
		imubc_lane #(
			.AVG_FRAMES(AVERAGE_FRAMES)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.raw      (raw[i]),
			.gravity  ((i == imubc_pkg::AXIS_ACC_Z) ? stat.gravity : '0),
			.threshold(stat.threshold),
			.frame    (frame[i]),
			.still    (still[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < imubc_pkg::AXES; i++) begin
				axis_q[i] <= command ? '0 : frame[i];
			end
			held_q  <= !command && !read_ok;
			phase_q <= command ? imubc_pkg::PHASE_WAIT : stat.phase_code;
			err_q   <= stat.err_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign acc_x_out   = axis_q[0];
	assign acc_y_out   = axis_q[1];
	assign acc_z_out   = axis_q[2];
	assign gyro_x_out  = axis_q[3];
	assign gyro_y_out  = axis_q[4];
	assign gyro_z_out  = axis_q[5];
	assign held        = held_q;
	assign phase       = phase_q;
	assign error_count = err_q;

endmodule

// ----- rtl/core/imubc_checker.sv -----
`timescale 1ns / 1ps

module imubc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        held,
	input logic [1:0]  phase,
	input logic [31:0] error_count
);

	logic beat;

	assign beat = out_valid && !out_stall;

	// consecutive beats: the error count moves by exactly one on a held frame
	a_err_step: assert property (@(posedge clk) disable iff (!arst_n)
		beat && $past(beat) |-> error_count == $past(error_count) + 32'(held))
		else $error("error_count step does not match held");

	// waiting never skips straight to running
	a_phase_order: assert property (@(posedge clk) disable iff (!arst_n)
		beat && $past(beat) && ($past(phase) == imubc_pkg::PHASE_WAIT)
		|-> phase != imubc_pkg::PHASE_RUN)
		else $error("phase jumped from waiting to running");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase != 2'd3)
		else $error("illegal phase code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error_count) && $stable(phase))
		else $error("stalled output beat changed");

endmodule

bind imu_bias_calibrate_correct_unit imubc_checker u_imubc_checker (.*);
